>>> sv/pmba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmba_pkg: shared constants and types for the priority map blend unit
// Register map, map size limits and fixed-point constants.
// ----------------------------------------------------------------------------
package pmba_pkg;

  localparam int MAX_DIM        = 1024;
  localparam int DIM_BITS       = $clog2(MAX_DIM);   // raster counters
  localparam int CFG_DIM_BITS   = 11;                // map_width / map_height
  localparam int GAIN_BITS      = 16;                // unsigned Q4.12
  localparam int GAIN_FRAC      = 12;
  localparam int RAD_BITS       = 16;                // unsigned Q10.6
  localparam int ROOT_BITS      = 17;                // radius result, Q.6
  localparam int DIR_BITS       = 11;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int VALUE_BITS_DEF = 24;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'd4096;

  // register indexes of the configuration port
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_MAP_WIDTH    = 3'd0,
    REG_MAP_HEIGHT   = 3'd1,
    REG_BLEND_MODE   = 3'd2,
    REG_PERIPH_GAIN  = 3'd3,
    REG_CENTER_GAIN  = 3'd4,
    REG_FIELD_RADIUS = 3'd5
  } cfg_reg_t;

  // size register clamped to 1..MAX_DIM
  function automatic logic [CFG_DIM_BITS-1:0] eff_dim(input logic [CFG_DIM_BITS-1:0] v);
    logic [CFG_DIM_BITS-1:0] r;
    if (v == '0) begin
      r = CFG_DIM_BITS'(1);
    end else if (v > CFG_DIM_BITS'(MAX_DIM)) begin
      r = CFG_DIM_BITS'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> sv/priority_map_blend_argmax_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_map_blend_argmax_unit: per-pixel priority blend with argmax search
// Channel    | dir | handshake           | contents
// cfg        | in  | cfg_we              | cfg_addr register index, cfg_wdata value
// s (pixel)  | in  | s_tvalid / s_tready | periph, central, history values
// m (result) | out | m_tvalid / m_tready | priority, fault, offsets; tlast = frame done
//
// One pixel at a time. Gained-max mode uses only the shared multiplier; weighted
// mode also runs on the shared shift/subtract unit (two 17-step square roots,
// one divide of VALUE_BITS+19 steps).
// Synchronous reset clears control, raster position and best tracking.
// A finished result waits in the output register; the next pixel is accepted
// meanwhile, and its result is held until that register frees up.
// ----------------------------------------------------------------------------
module priority_map_blend_argmax_unit #(
  parameter int VALUE_BITS = pmba_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pmba_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [pmba_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // periph_value, central_value, history_value (from bit 0 up)
  input  logic [((3*VALUE_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // priority_value, divide_fault, dir_x, dir_y (from bit 0 up)
  output logic [((VALUE_BITS+23+7)/8)*8-1:0]    m_tdata,
  output logic                                  m_tlast
);
  import pmba_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int OUT_W = ((VB+23+7)/8)*8;
  localparam int MAW   = 19;              // multiplier operand a
  localparam int MBW   = VB + 1;          // multiplier operand b
  localparam int PW    = MAW + MBW;       // product
  localparam int DW    = VB + 19;         // dividend / radicand shift register
  localparam int SW    = 20;              // partial remainder
  localparam int SUMW  = VB + 37;         // wide accumulate
  localparam int CNTW  = $clog2(DW+1);
  localparam int D2W   = 22;              // squared distance
  localparam int SPW   = PW - GAIN_FRAC;  // gained value

  typedef enum logic [4:0] {
    S_IDLE, S_ISSUE, S_MX_P, S_MX_C, S_W_DY, S_W_CX, S_W_CY, S_W_M2,
    S_SQ_D, S_RP, S_SQ_M, S_BRANCH, S_IN_P, S_IN_SUM, S_DIV_IN, S_IN_Q,
    S_OUT_DIV0, S_DIV_OUT, S_OUT_FL, S_OUT_FH, S_OUT_SUM, S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [CFG_DIM_BITS-1:0] map_width, map_height;
  logic                    blend_mode;
  logic [GAIN_BITS-1:0]    periph_gain, center_gain;
  logic [RAD_BITS-1:0]     field_radius;

  // raster and best tracking
  logic [DIM_BITS-1:0]     row_count, col_count, best_row, best_col;
  logic signed [VB-1:0]    best_value;
  logic                    have_best;

  // item registers
  logic signed [VB-1:0]    p_r, c_r, h_r;
  logic signed [11:0]      dx, dy;
  logic [D2W-1:0]          d2, m2;
  logic [ROOT_BITS-1:0]    rp;
  logic signed [SPW-1:0]   sp;
  logic signed [SUMW-1:0]  sum;
  logic                    neg;
  logic [ROOT_BITS-1:0]    fh;
  logic signed [VB-1:0]    prio_r;
  logic                    fault_r;

  // shared multiplier
  logic signed [MAW-1:0]   ma;
  logic signed [MBW-1:0]   mb;
  logic signed [PW-1:0]    prod;

  // shared shift/subtract unit (divide and square root)
  logic [DW-1:0]           acc, q;
  logic [SW-1:0]           rem;
  logic [ROOT_BITS-1:0]    dvs;
  logic [CNTW-1:0]         cnt;
  logic                    it_sqrt;
  logic [SW-1:0]           cand, trial;
  logic [SW:0]             diff;
  logic                    ge;

  // output register
  logic signed [VB-1:0]    o_prio;
  logic                    o_fault;
  logic signed [DIR_BITS-1:0] o_dx, o_dy;

  // derived geometry
  logic [CFG_DIM_BITS-1:0] w_eff, h_eff;
  logic [DIM_BITS-1:0]     cx, cy;
  logic [ROOT_BITS-1:0]    rc_ext, rc_m_rp, rp_m_rc;
  logic [GAIN_BITS-1:0]    gabs;
  logic [33:0]             factor_c;
  logic signed [SUMW-1:0]  n_sum, h_ext, quot, out_total;
  logic signed [SPW:0]     mx_res;

  assign w_eff   = eff_dim(map_width);
  assign h_eff   = eff_dim(map_height);
  assign cx      = w_eff[DIM_BITS:1];
  assign cy      = h_eff[DIM_BITS:1];
  assign rc_ext  = {1'b0, field_radius};
  assign rc_m_rp = rc_ext - rp;
  assign rp_m_rc = rp - rc_ext;
  assign gabs    = (periph_gain >= GAIN_ONE) ? periph_gain - GAIN_ONE : GAIN_ONE - periph_gain;
  assign factor_c = {{(34-GAIN_BITS){1'b0}}, GAIN_ONE} + q[33:0];
  assign h_ext   = {{(SUMW-VB){h_r[VB-1]}}, h_r};

  // saturate a wide signed value into VB bits
  function automatic logic signed [VB-1:0] sat(input logic signed [SUMW-1:0] v);
    logic signed [VB-1:0] r;
    if (v[SUMW-1:VB-1] == '0 || v[SUMW-1:VB-1] == '1) begin
      r = v[VB-1:0];
    end else if (v[SUMW-1]) begin
      r = {1'b1, {(VB-1){1'b0}}};
    end else begin
      r = {1'b0, {(VB-1){1'b1}}};
    end
    return r;
  endfunction

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_ISSUE: begin
        if (!blend_mode) begin
          ma = {3'b0, periph_gain};
          mb = {p_r[VB-1], p_r};
        end else begin
          ma = {{(MAW-12){dx[11]}}, dx};
          mb = {{(MBW-12){dx[11]}}, dx};
        end
      end
      S_MX_P: begin
        ma = {3'b0, center_gain};
        mb = {c_r[VB-1], c_r};
      end
      S_W_DY: begin
        ma = {{(MAW-12){dy[11]}}, dy};
        mb = {{(MBW-12){dy[11]}}, dy};
      end
      S_W_CX: begin
        ma = {{(MAW-DIM_BITS){1'b0}}, cx};
        mb = {{(MBW-DIM_BITS){1'b0}}, cx};
      end
      S_W_CY: begin
        ma = {{(MAW-DIM_BITS){1'b0}}, cy};
        mb = {{(MBW-DIM_BITS){1'b0}}, cy};
      end
      S_BRANCH: begin
        if (rp < rc_ext) begin
          ma = {2'b0, rc_m_rp};
          mb = {c_r[VB-1], c_r};
        end else begin
          ma = {2'b0, rp_m_rc};
          mb = {{(MBW-GAIN_BITS){1'b0}}, gabs};
        end
      end
      S_IN_P: begin
        ma = {2'b0, rp};
        mb = {p_r[VB-1], p_r};
      end
      S_OUT_FL: begin
        ma = {2'b0, factor_c[ROOT_BITS-1:0]};
        mb = {p_r[VB-1], p_r};
      end
      S_OUT_FH: begin
        ma = {2'b0, fh};
        mb = {p_r[VB-1], p_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // one step of restoring divide (1 bit) or square root (2 bits)
  always_comb begin
    cand  = it_sqrt ? {rem[SW-3:0], acc[DW-1:DW-2]} : {rem[SW-2:0], acc[DW-1]};
    trial = it_sqrt ? SW'({q[ROOT_BITS-1:0], 2'b01}) : SW'(dvs);
    diff  = {1'b0, cand} - {1'b0, trial};
    ge    = ~diff[SW];
  end

  // blend arithmetic feeding the result register
  always_comb begin
    n_sum     = sum + {{(SUMW-PW){prod[PW-1]}}, prod};
    quot      = neg ? -$signed({{(SUMW-DW){1'b0}}, q}) - SUMW'(rem != '0)
                    : $signed({{(SUMW-DW){1'b0}}, q});
    out_total = $signed(sum + ({{(SUMW-PW){prod[PW-1]}}, prod} <<< ROOT_BITS)) >>> GAIN_FRAC;
    mx_res    = ((sp > $signed(prod[PW-1:GAIN_FRAC])) ? {sp[SPW-1], sp}
                 : {prod[PW-1], prod[PW-1:GAIN_FRAC]}) - {{(SPW+1-VB){h_r[VB-1]}}, h_r};
  end

  // result and tracking helpers
  logic                 take, done;
  logic [DIM_BITS-1:0]  nb_row, nb_col;
  assign take   = !have_best || (prio_r > best_value);
  assign nb_row = take ? row_count : best_row;
  assign nb_col = take ? col_count : best_col;
  assign done   = ({1'b0, col_count} >= w_eff - 1'b1) && ({1'b0, row_count} >= h_eff - 1'b1);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = OUT_W'({o_dy, o_dx, o_fault, o_prio});

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width    <= 11'd64;
      map_height   <= 11'd64;
      blend_mode   <= 1'b0;
      periph_gain  <= GAIN_ONE;
      center_gain  <= GAIN_ONE;
      field_radius <= 16'd2048;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAP_WIDTH:    map_width    <= cfg_wdata[CFG_DIM_BITS-1:0];
        REG_MAP_HEIGHT:   map_height   <= cfg_wdata[CFG_DIM_BITS-1:0];
        REG_BLEND_MODE:   blend_mode   <= cfg_wdata[0];
        REG_PERIPH_GAIN:  periph_gain  <= cfg_wdata;
        REG_CENTER_GAIN:  center_gain  <= cfg_wdata;
        REG_FIELD_RADIUS: field_radius <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // sequencer, shared unit, tracking and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      row_count  <= '0;
      col_count  <= '0;
      best_row   <= '0;
      best_col   <= '0;
      best_value <= '0;
      have_best  <= 1'b0;
    end else begin
      // word taken and no new result loaded this cycle
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      // iteration step, active in all loop states
      if (state == S_SQ_D || state == S_SQ_M || state == S_DIV_IN || state == S_DIV_OUT) begin
        rem <= ge ? diff[SW-1:0] : cand;
        q   <= {q[DW-2:0], ge};
        acc <= it_sqrt ? (acc << 2) : (acc << 1);
        cnt <= cnt - 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            p_r     <= s_tdata[VB-1:0];
            c_r     <= s_tdata[2*VB-1:VB];
            h_r     <= s_tdata[3*VB-1:2*VB];
            dx      <= {2'b0, col_count} - {2'b0, cx};
            dy      <= {2'b0, row_count} - {2'b0, cy};
            fault_r <= 1'b0;
            state   <= S_ISSUE;
          end
        end
        S_ISSUE: state <= blend_mode ? S_W_DY : S_MX_P;
        S_MX_P: begin
          sp    <= prod[PW-1:GAIN_FRAC];
          state <= S_MX_C;
        end
        S_MX_C: begin
          prio_r <= sat({{(SUMW-SPW-1){mx_res[SPW]}}, mx_res});
          state  <= S_FIN;
        end
        S_W_DY: begin
          d2    <= prod[D2W-1:0];
          state <= S_W_CX;
        end
        S_W_CX: begin
          d2    <= d2 + prod[D2W-1:0];
          state <= S_W_CY;
        end
        S_W_CY: begin
          m2    <= prod[D2W-1:0];
          state <= S_W_M2;
        end
        S_W_M2: begin
          m2      <= m2 + prod[D2W-1:0];
          acc     <= {d2, {(DW-D2W){1'b0}}};
          rem     <= '0;
          q       <= '0;
          cnt     <= CNTW'(ROOT_BITS);
          it_sqrt <= 1'b1;
          state   <= S_SQ_D;
        end
        S_SQ_D: if (cnt == CNTW'(1)) state <= S_RP;
        S_RP: begin
          rp      <= q[ROOT_BITS-1:0];
          acc     <= {m2, {(DW-D2W){1'b0}}};
          rem     <= '0;
          q       <= '0;
          cnt     <= CNTW'(ROOT_BITS);
          it_sqrt <= 1'b1;
          state   <= S_SQ_M;
        end
        S_SQ_M: if (cnt == CNTW'(1)) state <= S_BRANCH;
        S_BRANCH: begin
          if (rp < rc_ext) begin
            state <= S_IN_P;
          end else if (q[ROOT_BITS-1:0] <= rc_ext) begin
            // zero or negative divisor outside the field
            fault_r <= 1'b1;
            prio_r  <= '0;
            state   <= S_FIN;
          end else begin
            dvs   <= q[ROOT_BITS-1:0] - rc_ext;
            state <= S_OUT_DIV0;
          end
        end
        S_IN_P: begin
          sum   <= {{(SUMW-PW){prod[PW-1]}}, prod};
          state <= S_IN_SUM;
        end
        S_IN_SUM: begin
          neg     <= n_sum[SUMW-1];
          acc     <= n_sum[SUMW-1] ? DW'(-n_sum) : DW'(n_sum);
          rem     <= '0;
          q       <= '0;
          dvs     <= rc_ext;
          cnt     <= CNTW'(DW);
          it_sqrt <= 1'b0;
          state   <= S_DIV_IN;
        end
        S_DIV_IN: if (cnt == CNTW'(1)) state <= S_IN_Q;
        S_IN_Q: begin
          prio_r <= sat(quot - h_ext);
          state  <= S_FIN;
        end
        S_OUT_DIV0: begin
          acc     <= DW'(prod);
          rem     <= '0;
          q       <= '0;
          cnt     <= CNTW'(DW);
          it_sqrt <= 1'b0;
          state   <= S_DIV_OUT;
        end
        S_DIV_OUT: if (cnt == CNTW'(1)) state <= S_OUT_FL;
        S_OUT_FL: begin
          fh    <= factor_c[33:ROOT_BITS];
          state <= S_OUT_FH;
        end
        S_OUT_FH: begin
          sum   <= {{(SUMW-PW){prod[PW-1]}}, prod};
          state <= S_OUT_SUM;
        end
        S_OUT_SUM: begin
          prio_r <= sat(out_total - h_ext);
          state  <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            o_prio   <= prio_r;
            o_fault  <= fault_r;
            m_tlast  <= done;
            if (done) begin
              o_dx       <= {1'b0, nb_col} - {1'b0, cx};
              o_dy       <= {1'b0, nb_row} - {1'b0, cy};
              row_count  <= '0;
              col_count  <= '0;
              best_row   <= '0;
              best_col   <= '0;
              best_value <= '0;
              have_best  <= 1'b0;
            end else begin
              o_dx <= '0;
              o_dy <= '0;
              if (take) begin
                best_value <= prio_r;
                best_row   <= row_count;
                best_col   <= col_count;
                have_best  <= 1'b1;
              end
              if ({1'b0, col_count} >= w_eff - 1'b1) begin
                col_count <= '0;
                row_count <= row_count + 1'b1;
              end else begin
                col_count <= col_count + 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a faulted pixel always reports zero priority
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_fault |-> o_prio == '0)
    else $error("fault word with nonzero priority");

  // offsets only travel with the frame's last word
  a_dir_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> o_dx == '0 && o_dy == '0)
    else $error("offset outside frame end");

  // one pixel in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a pixel while busy");

  // a finished result waits while the output register is blocked
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && m_tvalid && !m_tready |=> state == S_FIN)
    else $error("result dropped while output stalled");

endmodule
